// ----- hw/rtl/spc_pkg.sv -----
package spc_pkg;

    // Field widths
    localparam int COORD_WIDTH = 16;
    localparam int COUNT_WIDTH = 10;
    localparam int ID_WIDTH    = 12;
    localparam int JOIN_WIDTH  = 16;

    // Derived datapath widths
    localparam int SUM_WIDTH  = COORD_WIDTH + COUNT_WIDTH;
    localparam int MUL_WIDTH  = (COORD_WIDTH > JOIN_WIDTH) ? COORD_WIDTH : JOIN_WIDTH;
    localparam int SQ_WIDTH   = 2 * MUL_WIDTH;
    localparam int D2_WIDTH   = (SQ_WIDTH + 1 > 64) ? 64 : SQ_WIDTH + 1;
    localparam int ROOT_WIDTH = (D2_WIDTH + 1) / 2;
    localparam int WMM_WIDTH  = COORD_WIDTH + 1;

    // Shift/subtract unit sizing
    localparam int REM_WIDTH = (COUNT_WIDTH + 1 > ROOT_WIDTH + 2) ?
                               COUNT_WIDTH + 1 : ROOT_WIDTH + 2;
    localparam int SRC_WIDTH = (SUM_WIDTH > 2 * ROOT_WIDTH) ? SUM_WIDTH : 2 * ROOT_WIDTH;
    localparam int ITER_MAX  = (SUM_WIDTH > ROOT_WIDTH) ? SUM_WIDTH : ROOT_WIDTH;
    localparam int ITER_CNT_WIDTH = $clog2(ITER_MAX + 1);

    // Stream and configuration port widths
    localparam int IN_DATA_WIDTH   = ((2 * COORD_WIDTH) + 7) / 8 * 8;
    localparam int OUT_FIELD_WIDTH = ID_WIDTH + 2 * COORD_WIDTH + WMM_WIDTH;
    localparam int OUT_DATA_WIDTH  = (OUT_FIELD_WIDTH + 7) / 8 * 8;
    localparam int CFG_DATA_WIDTH  = (JOIN_WIDTH > COUNT_WIDTH) ? JOIN_WIDTH : COUNT_WIDTH;
    localparam int CFG_INDEX_WIDTH = 2;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_JOIN_DISTANCE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_POINTS    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_POINTS    = 2'd2;

    // Reset values and limits
    localparam logic [JOIN_WIDTH-1:0]  JOIN_RESET = JOIN_WIDTH'(600);
    localparam logic [COUNT_WIDTH-1:0] MIN_RESET  = COUNT_WIDTH'(3);
    localparam logic [COUNT_WIDTH-1:0] MAX_RESET  = COUNT_WIDTH'(35);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
    localparam logic [ID_WIDTH-1:0]    ID_MAX     = '1;

    typedef enum logic
    {
        MODE_DIV,
        MODE_SQRT
    } iter_mode_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } iter_status_t;

endpackage

// ----- hw/rtl/spc_sqr.sv -----
module spc_sqr
(
    input  logic                                 clk,
    input  logic                                 use_join,
    input  logic signed [spc_pkg::COORD_WIDTH-1:0] a,
    input  logic signed [spc_pkg::COORD_WIDTH-1:0] b,
    input  logic [spc_pkg::JOIN_WIDTH-1:0]       join_dist,
    output logic [spc_pkg::SQ_WIDTH-1:0]         prod
);
    import spc_pkg::*;

    logic [COORD_WIDTH:0]   diff;
    logic [COORD_WIDTH:0]   diff_neg;
    logic [MUL_WIDTH-1:0]   mag_next;
    logic [MUL_WIDTH-1:0]   mag_reg;
    logic [SQ_WIDTH-1:0]    prod_reg;

    // Magnitude of the coordinate difference, or the join distance
    always_comb
    begin
        diff     = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        diff_neg = (COORD_WIDTH+1)'(0) - diff;
        if (use_join)
        begin
            mag_next = MUL_WIDTH'(join_dist);
        end
        else if (diff[COORD_WIDTH])
        begin
            mag_next = MUL_WIDTH'(diff_neg[COORD_WIDTH-1:0]);
        end
        else
        begin
            mag_next = MUL_WIDTH'(diff[COORD_WIDTH-1:0]);
        end
    end

    // Two-stage pipe: magnitude, then square
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        prod_reg <= mag_reg * mag_reg;
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/spc_iter.sv -----
module spc_iter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  spc_pkg::iter_mode_t               mode,
    input  logic [spc_pkg::SRC_WIDTH-1:0]     operand,
    input  logic [spc_pkg::COUNT_WIDTH-1:0]   divisor,
    output spc_pkg::iter_status_t             status,
    output logic [spc_pkg::SRC_WIDTH-1:0]     result
);
    import spc_pkg::*;

    localparam int SHIFT_DIV  = SRC_WIDTH - SUM_WIDTH;
    localparam int SHIFT_SQRT = SRC_WIDTH - 2 * ROOT_WIDTH;

    iter_mode_t                 mode_reg;
    logic [COUNT_WIDTH-1:0]     div_reg;
    logic [SRC_WIDTH-1:0]       src_reg;
    logic [REM_WIDTH-1:0]       rem_reg;
    logic [SRC_WIDTH-1:0]       acc_reg;
    logic [ITER_CNT_WIDTH-1:0]  cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [REM_WIDTH-1:0]       shifted;
    logic [REM_WIDTH-1:0]       trial;
    logic [REM_WIDTH:0]         diff;
    logic                       ge;

    // One restoring step: a quotient bit or a root bit
    always_comb
    begin
        if (mode_reg == MODE_DIV)
        begin
            shifted = {rem_reg[REM_WIDTH-2:0], src_reg[SRC_WIDTH-1]};
            trial   = REM_WIDTH'(div_reg);
        end
        else
        begin
            shifted = {rem_reg[REM_WIDTH-3:0], src_reg[SRC_WIDTH-1 -: 2]};
            trial   = {acc_reg[REM_WIDTH-3:0], 2'b01};
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = ~diff[REM_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= (mode == MODE_DIV) ? ITER_CNT_WIDTH'(SUM_WIDTH)
                                           : ITER_CNT_WIDTH'(ROOT_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == ITER_CNT_WIDTH'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mode;
            div_reg  <= divisor;
            rem_reg  <= '0;
            acc_reg  <= '0;
            src_reg  <= (mode == MODE_DIV) ? (operand << SHIFT_DIV) : (operand << SHIFT_SQRT);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[REM_WIDTH-1:0] : shifted;
            acc_reg <= {acc_reg[SRC_WIDTH-2:0], ge};
            src_reg <= (mode_reg == MODE_DIV) ? (src_reg << 1) : (src_reg << 2);
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = acc_reg;

endmodule

// ----- hw/rtl/scan_point_clusterer.sv -----
// Scan point clusterer: jump-distance segmentation of a laser scan.
// A point that reports nothing holds s_tready low from its transaction until the sequencer is
// back in S_IDLE, so the block takes no new point while one is in flight. Each reported cluster
// adds the width terms through the squaring pipe, then two divisions and one square root on the
// shared shift/subtract unit (one bit a cycle), plus any wait for the output register to drain.
// Scan end also passes through S_CLEAR; at most two results a point. Reset (rst_n, async,
// low): registers to 600/3/35, no open cluster, next id 1.
module scan_point_clusterer
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [spc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [spc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    // point stream in
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [spc_pkg::IN_DATA_WIDTH-1:0]      s_tdata,  // point_x, point_y
    input  logic                                   s_tlast,  // scan_end
    // cluster stream out
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [spc_pkg::OUT_DATA_WIDTH-1:0]     m_tdata,  // obstacle_id, center_x, center_y,
                                                             // width_mm, zero pad
    output logic                                   m_tlast   // last_of_run
);
    import spc_pkg::*;

    typedef enum logic [4:0]
    {
        S_IDLE,
        S_LIM,
        S_DX,
        S_DY,
        S_PX,
        S_PY,
        S_DECIDE,
        S_WX,
        S_WY,
        S_WPX,
        S_WPY,
        S_DIVX,
        S_DIVY,
        S_SQRT,
        S_EMIT,
        S_UPDATE,
        S_CLEAR
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [JOIN_WIDTH-1:0]  join_reg;
    logic [COUNT_WIDTH-1:0] min_reg;
    logic [COUNT_WIDTH-1:0] max_reg;

    // Latched input point
    logic signed [COORD_WIDTH-1:0] in_x_reg;
    logic signed [COORD_WIDTH-1:0] in_y_reg;
    logic                          in_end_reg;

    // Open cluster
    logic                          open_reg;
    logic [COUNT_WIDTH-1:0]        count_reg;
    logic signed [SUM_WIDTH-1:0]   sum_x_reg;
    logic signed [SUM_WIDTH-1:0]   sum_y_reg;
    logic signed [COORD_WIDTH-1:0] first_x_reg;
    logic signed [COORD_WIDTH-1:0] first_y_reg;
    logic signed [COORD_WIDTH-1:0] prev_x_reg;
    logic signed [COORD_WIDTH-1:0] prev_y_reg;
    logic [ID_WIDTH-1:0]           next_id_reg;

    // Per-point working registers
    logic [SQ_WIDTH-1:0]    lim_reg;
    logic [SQ_WIDTH-1:0]    sq_reg;
    logic [D2_WIDTH-1:0]    d2_reg;
    logic                   join_flag_reg;
    logic                   q2_reg;
    logic                   phase_reg;
    logic                   last_reg;
    logic [COORD_WIDTH-1:0] qx_reg;
    logic [COORD_WIDTH-1:0] qy_reg;

    // Output register
    logic                   out_valid_reg;
    logic [ID_WIDTH-1:0]    out_id_reg;
    logic [COORD_WIDTH-1:0] out_cx_reg;
    logic [COORD_WIDTH-1:0] out_cy_reg;
    logic [WMM_WIDTH-1:0]   out_w_reg;
    logic                   out_last_reg;

    // Squaring pipe
    logic                          sqr_use_join;
    logic signed [COORD_WIDTH-1:0] sqr_a;
    logic signed [COORD_WIDTH-1:0] sqr_b;
    logic [SQ_WIDTH-1:0]           prod;

    // Shift/subtract unit
    logic                   iter_start;
    iter_mode_t             iter_mode;
    logic [SRC_WIDTH-1:0]   iter_operand;
    iter_status_t           iter_st;
    logic [SRC_WIDTH-1:0]   iter_result;

    // Combinational helpers
    logic [SQ_WIDTH:0]      d2_sum;
    logic [D2_WIDTH-1:0]    d2_sat;
    logic                   join_now;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [COUNT_WIDTH-1:0] count_after;
    logic                   q1;
    logic                   q2;
    logic                   out_free;
    logic [SUM_WIDTH-1:0]   mag_x;
    logic [SUM_WIDTH-1:0]   mag_y;
    logic                   quot_neg;
    logic [SUM_WIDTH-1:0]   quot;
    logic [SUM_WIDTH-1:0]   quot_signed;
    logic [COORD_WIDTH-1:0] centre;

    spc_sqr u_sqr
    (
        .clk       (clk),
        .use_join  (sqr_use_join),
        .a         (sqr_a),
        .b         (sqr_b),
        .join_dist (join_reg),
        .prod      (prod)
    );

    spc_iter u_iter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (iter_start),
        .mode    (iter_mode),
        .operand (iter_operand),
        .divisor (count_reg),
        .status  (iter_st),
        .result  (iter_result)
    );

    // Steer the squaring pipe. A product comes out of the magnitude and square registers after its
    // operands are issued, so issue and pick-up states are paired below.
    always_comb
    begin
        sqr_use_join = 1'b0;
        sqr_a        = prev_x_reg;
        sqr_b        = in_x_reg;
        case (state_reg)
            S_LIM:
            begin
                sqr_use_join = 1'b1;
            end
            S_DY:
            begin
                sqr_a = prev_y_reg;
                sqr_b = in_y_reg;
            end
            S_WX:
            begin
                sqr_a = first_x_reg;
                sqr_b = prev_x_reg;
            end
            S_WY:
            begin
                sqr_a = first_y_reg;
                sqr_b = prev_y_reg;
            end
            default:
            begin
                sqr_a = prev_x_reg;
                sqr_b = in_x_reg;
            end
        endcase
    end

    // Squared distance: sum of the two squares, saturated to 64 bits when
    // the coordinates are wide enough to overflow it
    always_comb
    begin
        d2_sum = (SQ_WIDTH+1)'(sq_reg) + (SQ_WIDTH+1)'(prod);
        if ((d2_sum >> D2_WIDTH) != '0)
        begin
            d2_sat = '1;
        end
        else
        begin
            d2_sat = d2_sum[D2_WIDTH-1:0];
        end
        join_now = open_reg && ((SQ_WIDTH+1)'(d2_sat) <= (SQ_WIDTH+1)'(lim_reg));
    end

    // Cluster verdicts: q1 for the cluster this point closes, q2 for the
    // cluster the end-of-scan mark closes after this point is taken in
    always_comb
    begin
        count_inc   = (count_reg < COUNT_MAX) ? (count_reg + 1'b1) : count_reg;
        count_after = join_flag_reg ? count_inc : COUNT_WIDTH'(1);
        q1          = !join_flag_reg && open_reg &&
                      (count_reg > min_reg) && (count_reg < max_reg);
        q2          = in_end_reg && (count_after > min_reg) && (count_after < max_reg);
        out_free    = !out_valid_reg || m_tready;
    end

    // Sum magnitudes into the divider, and the sign put back on the quotient
    always_comb
    begin
        mag_x       = sum_x_reg[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - sum_x_reg) : sum_x_reg;
        mag_y       = sum_y_reg[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - sum_y_reg) : sum_y_reg;
        quot_neg    = (state_reg == S_DIVX) ? sum_x_reg[SUM_WIDTH-1] : sum_y_reg[SUM_WIDTH-1];
        quot        = iter_result[SUM_WIDTH-1:0];
        quot_signed = quot_neg ? (SUM_WIDTH'(0) - quot) : quot;
        centre      = quot_signed[COORD_WIDTH-1:0];
    end

    // Shift/subtract unit requests: x division, y division, then the root
    always_comb
    begin
        iter_start   = 1'b0;
        iter_mode    = MODE_DIV;
        iter_operand = SRC_WIDTH'(mag_x);
        case (state_reg)
            S_WPY:
            begin
                iter_start = 1'b1;
            end
            S_DIVX:
            begin
                iter_start   = iter_st.done;
                iter_operand = SRC_WIDTH'(mag_y);
            end
            S_DIVY:
            begin
                iter_start   = iter_st.done;
                iter_mode    = MODE_SQRT;
                iter_operand = SRC_WIDTH'(d2_reg);
            end
            default:
            begin
                iter_start = 1'b0;
            end
        endcase
    end

    // Configuration writes; an index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            join_reg <= JOIN_RESET;
            min_reg  <= MIN_RESET;
            max_reg  <= MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_JOIN_DISTANCE: join_reg <= cfg_data[JOIN_WIDTH-1:0];
                REG_MIN_POINTS:    min_reg  <= cfg_data[COUNT_WIDTH-1:0];
                REG_MAX_POINTS:    max_reg  <= cfg_data[COUNT_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    // Sequencer, cluster state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            open_reg      <= 1'b0;
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            next_id_reg   <= ID_WIDTH'(1);
            out_valid_reg <= 1'b0;
            join_flag_reg <= 1'b0;
            q2_reg        <= 1'b0;
            phase_reg     <= 1'b0;
            last_reg      <= 1'b0;
            in_end_reg    <= 1'b0;
        end
        else
        begin
            // Drop the result once the downstream side takes it; in S_EMIT the
            // load below decides the valid flag instead
            if (out_valid_reg && m_tready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        in_x_reg   <= s_tdata[COORD_WIDTH-1:0];
                        in_y_reg   <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
                        in_end_reg <= s_tlast;
                        state_reg  <= S_LIM;
                    end
                end
                S_LIM:
                begin
                    state_reg <= S_DX;
                end
                S_DX:
                begin
                    state_reg <= S_DY;
                end
                S_DY:
                begin
                    lim_reg   <= prod;
                    state_reg <= S_PX;
                end
                S_PX:
                begin
                    sq_reg    <= prod;
                    state_reg <= S_PY;
                end
                S_PY:
                begin
                    join_flag_reg <= join_now;
                    state_reg     <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    q2_reg <= q2;
                    if (q1)
                    begin
                        // Report the closing cluster before the point overwrites it
                        phase_reg <= 1'b0;
                        last_reg  <= !q2;
                        state_reg <= S_WX;
                    end
                    else
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_WX:
                begin
                    state_reg <= S_WY;
                end
                S_WY:
                begin
                    state_reg <= S_WPX;
                end
                S_WPX:
                begin
                    sq_reg    <= prod;
                    state_reg <= S_WPY;
                end
                S_WPY:
                begin
                    d2_reg    <= d2_sat;
                    state_reg <= S_DIVX;
                end
                S_DIVX:
                begin
                    if (iter_st.done)
                    begin
                        qx_reg    <= centre;
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    if (iter_st.done)
                    begin
                        qy_reg    <= centre;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (iter_st.done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // Hold until the output register is free; the root stays
                    // on the unit's result until its next start
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= next_id_reg;
                        out_cx_reg    <= qx_reg;
                        out_cy_reg    <= qy_reg;
                        out_w_reg     <= iter_result[WMM_WIDTH-1:0];
                        out_last_reg  <= last_reg;
                        next_id_reg   <= (next_id_reg == ID_MAX) ? ID_WIDTH'(1)
                                                                 : next_id_reg + 1'b1;
                        state_reg     <= phase_reg ? S_CLEAR : S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    if (join_flag_reg)
                    begin
                        // Saturated count: the point still moves prev, not the sums
                        if (count_reg < COUNT_MAX)
                        begin
                            count_reg <= count_inc;
                            sum_x_reg <= sum_x_reg + SUM_WIDTH'(in_x_reg);
                            sum_y_reg <= sum_y_reg + SUM_WIDTH'(in_y_reg);
                        end
                    end
                    else
                    begin
                        open_reg    <= 1'b1;
                        count_reg   <= COUNT_WIDTH'(1);
                        sum_x_reg   <= SUM_WIDTH'(in_x_reg);
                        sum_y_reg   <= SUM_WIDTH'(in_y_reg);
                        first_x_reg <= in_x_reg;
                        first_y_reg <= in_y_reg;
                    end
                    prev_x_reg <= in_x_reg;
                    prev_y_reg <= in_y_reg;

                    if (!in_end_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (q2_reg)
                    begin
                        // Scan end: report the cluster this point leaves open
                        phase_reg <= 1'b1;
                        last_reg  <= 1'b1;
                        state_reg <= S_WX;
                    end
                    else
                    begin
                        state_reg <= S_CLEAR;
                    end
                end
                S_CLEAR:
                begin
                    open_reg    <= 1'b0;
                    count_reg   <= '0;
                    sum_x_reg   <= '0;
                    sum_y_reg   <= '0;
                    first_x_reg <= '0;
                    first_y_reg <= '0;
                    prev_x_reg  <= '0;
                    prev_y_reg  <= '0;
                    next_id_reg <= ID_WIDTH'(1);
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_DATA_WIDTH'({out_w_reg, out_cy_reg, out_cx_reg, out_id_reg});

    // The shared unit is never restarted in the middle of a computation
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        iter_start |-> !iter_st.busy)
        else $error("shift/subtract unit started while busy");

    // A new point is only taken once the shared unit has gone quiet
    a_ready_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !iter_st.busy)
        else $error("input ready while shift/subtract unit busy");

    // A result loaded from the sequencer shows up with a non-zero id
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> (m_tvalid && m_tdata[ID_WIDTH-1:0] != '0))
        else $error("emitted cluster missing or with id zero");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

    import spc_pkg::*;

    localparam int          CYCLE_LIMIT = 2_500_000;
    localparam int          COORD_HI    = 2 ** (COORD_WIDTH - 1) - 1;
    localparam int          COORD_LO    = -(2 ** (COORD_WIDTH - 1));
    // index 3 decodes to no register; writes there must leave the block untouched
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

    // One reported obstacle, fields in the order they sit in m_tdata
    typedef struct packed
    {
        logic [ID_WIDTH-1:0]           id;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic [WMM_WIDTH-1:0]          width;
        logic                          last;
    } obstacle_t;

    // Mirrors the segmentation state and holds the obstacles still owed by the block
    class cluster_scoreboard;
        logic [JOIN_WIDTH-1:0]         join_dist;
        logic [COUNT_WIDTH-1:0]        min_pts;
        logic [COUNT_WIDTH-1:0]        max_pts;
        bit                            open;
        logic [COUNT_WIDTH-1:0]        count;
        logic signed [SUM_WIDTH-1:0]   sum_x;
        logic signed [SUM_WIDTH-1:0]   sum_y;
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] prev_x;
        logic signed [COORD_WIDTH-1:0] prev_y;
        logic [ID_WIDTH-1:0]           next_id;
        obstacle_t                     owed_q[$];
        int                            errors;
        int                            points;
        int                            matched;

        function new();
            join_dist = JOIN_RESET;
            min_pts   = MIN_RESET;
            max_pts   = MAX_RESET;
            next_id   = 1;
            errors    = 0;
            points    = 0;
            matched   = 0;
            drop_cluster();
        endfunction

        function void drop_cluster();
            open    = 1'b0;
            count   = '0;
            sum_x   = '0;
            sum_y   = '0;
            first_x = '0;
            first_y = '0;
            prev_x  = '0;
            prev_y  = '0;
        endfunction

        function void set_register(logic [CFG_INDEX_WIDTH-1:0] idx,
                                   logic [CFG_DATA_WIDTH-1:0] val);
            case (idx)
                REG_JOIN_DISTANCE: join_dist = val[JOIN_WIDTH-1:0];
                REG_MIN_POINTS:    min_pts   = val[COUNT_WIDTH-1:0];
                REG_MAX_POINTS:    max_pts   = val[COUNT_WIDTH-1:0];
                default:           ;
            endcase
        endfunction

        function longint unsigned gap_sq(longint ax, longint ay, longint bx, longint by);
            longint dx;
            longint dy;
            dx = (ax > bx) ? ax - bx : bx - ax;
            dy = (ay > by) ? ay - by : by - ay;
            return longint'(dx * dx + dy * dy);
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = WMM_WIDTH; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        // Evaluate the open cluster; true when it passes both thresholds
        function bit close_cluster(output obstacle_t c);
            longint n;
            c = '0;
            if (!open || count == 0 || !(count > min_pts && count < max_pts))
                return 1'b0;
            n       = count;
            c.id    = next_id;
            c.cx    = COORD_WIDTH'(longint'(sum_x) / n);
            c.cy    = COORD_WIDTH'(longint'(sum_y) / n);
            c.width = WMM_WIDTH'(floor_root(gap_sq(first_x, first_y, prev_x, prev_y)));
            next_id = (next_id == ID_MAX) ? ID_WIDTH'(1) : next_id + 1'b1;
            return 1'b1;
        endfunction

        function void note_point(logic signed [COORD_WIDTH-1:0] x,
                                 logic signed [COORD_WIDTH-1:0] y, logic scan_end);
            obstacle_t       c[2];
            int              n;
            longint unsigned lim;
            n   = 0;
            lim = join_dist;
            lim = lim * lim;
            points++;
            if (open && gap_sq(prev_x, prev_y, x, y) <= lim)
            begin
                // a saturated count freezes the sums but the chain still follows the point
                if (count != COUNT_MAX)
                begin
                    count++;
                    sum_x += x;
                    sum_y += y;
                end
                prev_x = x;
                prev_y = y;
            end
            else
            begin
                if (close_cluster(c[n]))
                    n++;
                open    = 1'b1;
                count   = 1;
                sum_x   = x;
                sum_y   = y;
                first_x = x;
                first_y = y;
                prev_x  = x;
                prev_y  = y;
            end
            if (scan_end)
            begin
                if (close_cluster(c[n]))
                    n++;
                drop_cluster();
                next_id = 1;
            end
            if (n > 0)
                c[n-1].last = 1'b1;
            for (int k = 0; k < n; k++)
                owed_q.insert(owed_q.size(), c[k]);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_obstacle(logic [OUT_DATA_WIDTH-1:0] data, logic last);
            obstacle_t want;
            obstacle_t got;
            got.id    = data[0 +: ID_WIDTH];
            got.cx    = data[ID_WIDTH +: COORD_WIDTH];
            got.cy    = data[ID_WIDTH + COORD_WIDTH +: COORD_WIDTH];
            got.width = data[ID_WIDTH + 2 * COORD_WIDTH +: WMM_WIDTH];
            got.last  = last;
            if (owed_q.size() == 0)
            begin
                errors++;
                $display("%0t: obstacle with nothing owed, expected none, actual id %0d",
                         $time, got.id);
                return;
            end
            want = owed_q.pop_front();
            matched++;
            compare_field("obstacle_id", want.id, got.id);
            compare_field("center_x", want.cx, got.cx);
            compare_field("center_y", want.cy, got.cy);
            compare_field("width_mm", want.width, got.width);
            compare_field("last_of_run", want.last, got.last);
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [IN_DATA_WIDTH-1:0]   s_tdata   = '0;   // point_x, point_y
    logic                       s_tlast   = 1'b0; // scan_end
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [OUT_DATA_WIDTH-1:0]  m_tdata;          // obstacle_id, center_x, center_y,
                                                  // width_mm, zero pad
    logic                       m_tlast;          // last_of_run

    cluster_scoreboard sb;
    int                send_idle   = 0;  // per cent of cycles the point source holds off
    int                recv_idle   = 0;  // per cent of cycles the sink stalls
    int                settings    = 0;
    int unsigned       cycle_count = 0;

    scan_point_clusterer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sink: check every obstacle transaction, then decide whether to stall next cycle
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_obstacle(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(input int v);
        if (v > COORD_HI)
            return COORD_WIDTH'(COORD_HI);
        if (v < COORD_LO)
            return COORD_WIDTH'(COORD_LO);
        return COORD_WIDTH'(v);
    endfunction

    // Offer one point, idling at random first; hold tvalid high once raised
    task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
                              input logic signed [COORD_WIDTH-1:0] y, input logic scan_end);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= scan_end;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_point(x, y, scan_end);
    endtask

    // Drop tvalid and wait until every owed obstacle has arrived, then let the
    // block finish any point that reports nothing
    task automatic settle(input int tail);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.owed_q.size() != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_register(idx, val);
    endtask

    // Only call with the block idle. Count registers get junk in the unused upper bits.
    task automatic program_regs(input int gap_mm, input int min_pts, input int max_pts);
        logic [CFG_DATA_WIDTH-1:0] val;
        write_reg(REG_JOIN_DISTANCE, CFG_DATA_WIDTH'(gap_mm));
        val = CFG_DATA_WIDTH'($urandom);
        val[COUNT_WIDTH-1:0] = COUNT_WIDTH'(min_pts);
        write_reg(REG_MIN_POINTS, val);
        val = CFG_DATA_WIDTH'($urandom);
        val[COUNT_WIDTH-1:0] = COUNT_WIDTH'(max_pts);
        write_reg(REG_MAX_POINTS, val);
        write_reg(REG_SPARE, CFG_DATA_WIDTH'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    task automatic program_random();
        int lo;
        lo = $urandom_range(5);
        program_regs($urandom_range(1500), lo, lo + $urandom_range(15, 1));
    endtask

    // Mostly chains of nearby points sized around the thresholds, some stray points,
    // scan ends at random and now and then a full pause of the source
    task automatic scan_traffic(input int items);
        int sent;
        int size;
        int lo;
        int hi;
        int step;
        int cx;
        int cy;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_point(COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
                           $urandom_range(99) < 8);
                sent++;
            end
            else
            begin
                lo = (sb.min_pts > 1) ? int'(sb.min_pts) - 1 : 1;
                hi = (sb.max_pts < 40) ? int'(sb.max_pts) + 1 : lo + 20;
                if (hi < lo)
                    hi = lo;
                size = $urandom_range(hi, lo);
                step = int'(sb.join_dist) / 2;
                if (step > 16000)
                    step = 16000;
                cx = int'($urandom_range(65535)) + COORD_LO;
                cy = int'($urandom_range(65535)) + COORD_LO;
                for (int k = 0; k < size && sent < items; k++)
                begin
                    send_point(clamp_coord(cx), clamp_coord(cy),
                               ($urandom_range(99) < 3) ||
                               (k == size - 1 && $urandom_range(99) < 20));
                    sent++;
                    // clamp keeps the next point inside range without widening the step
                    cx = clamp_coord(cx + int'($urandom_range(2 * step)) - step);
                    cy = clamp_coord(cy + int'($urandom_range(2 * step)) - step);
                end
            end
            if ($urandom_range(99) < 2)
                settle(0);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds: edge coordinates, join boundary at exactly the distance,
        // a three-point cluster rejected, a four-point one closed by scan end
        send_idle = 24;
        recv_idle = 76;
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(16'sd32167, 16'sd32767, 1'b0);
        send_point(16'sd31566, 16'sd32767, 1'b0);
        send_point(16'sd31600, 16'sd32700, 1'b0);
        send_point(16'sd31650, 16'sd32650, 1'b0);
        send_point(16'sd31700, 16'sd32600, 1'b1);
        // negative centroid that truncates toward zero, closed by a jump on scan end
        send_point(-16'sd1, -16'sd2, 1'b0);
        send_point(-16'sd2, -16'sd2, 1'b0);
        send_point(-16'sd2, -16'sd1, 1'b0);
        send_point(-16'sd1, 16'sd0, 1'b0);
        send_point(-16'sd1, 16'sd0, 1'b0);
        send_point(16'sd20000, -16'sd20000, 1'b1);
        scan_traffic(110);

        // Zero join distance, single-point clusters: two obstacles from one point,
        // a repeated point that joins, and the id restarting after scan end
        settle(200);
        program_regs(0, 0, 2);
        send_point(16'sd100, 16'sd100, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b1);
        send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd7, 16'sd7, 1'b1);
        scan_traffic(40);

        // Swap the idling: slow source, eager sink
        settle(200);
        send_idle = 76;
        recv_idle = 24;
        for (int p = 0; p < 3; p++)
        begin
            program_random();
            scan_traffic(50);
            settle(200);
        end

        // Thresholds that admit nothing, widest join
        program_regs(2 ** JOIN_WIDTH - 1, 2 ** COUNT_WIDTH - 1, 0);
        scan_traffic(30);
        settle(200);

        // Widest obstacle: corner to corner through the origin
        program_regs(2 ** JOIN_WIDTH - 1, 0, 2 ** COUNT_WIDTH - 1);
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b1);
        scan_traffic(60);
        settle(200);

        // Neither side idles from here on
        send_idle = 0;
        recv_idle = 0;

        // Long chain in the corner of the range, x near its most negative and y at its most positive,
        // closed by a jump on the scan end point
        program_regs(10, 30, 60);
        for (int k = 0; k < 45; k++)
            send_point(clamp_coord(COORD_LO + k), 16'sd32767, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
        settle(200);

        // A run of single-point obstacles in one scan
        program_regs(0, 0, 2);
        for (int k = 0; k < 20; k++)
            send_point(COORD_WIDTH'(7 * k), COORD_WIDTH'(13 * k - 1000), k == 19);
        settle(200);

        program_random();
        scan_traffic(80);
        settle(200);

        $display("tb: %0d points in, %0d obstacles checked over %0d register settings",
                 sb.points, sb.matched, settings);
        $display("tb: covered join limits 0 to max, long chains, single-point runs, "
                 , "both idle mixes");
        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
